### hdl/jfe_pkg.sv
// Shared types, marker constants and helper functions for the JPEG frame extractor.
// Used by jfe_front, jfe_queue, jfe_back and jpeg_frame_extractor_core.
`default_nettype none

package jfe_pkg;

    localparam int CFG_WIDTH   = 23;
    localparam int COUNT_WIDTH = 23;
    localparam int BYTE_WIDTH  = 8;

    localparam logic [BYTE_WIDTH-1:0] MARK_PREFIX = 8'hFF;
    localparam logic [BYTE_WIDTH-1:0] MARK_SOI    = 8'hD8;
    localparam logic [BYTE_WIDTH-1:0] MARK_EOI    = 8'hD9;
    localparam logic [BYTE_WIDTH-1:0] PAD_BYTE    = 8'h00;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // At most four output bytes per command
    localparam int IDX_WIDTH = 2;
    localparam int LEN_WIDTH = 3;

    typedef enum logic [2:0] {
        K_NONE,
        K_PAD,
        K_EOI,
        K_BODY,
        K_SOI
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [BYTE_WIDTH-1:0] data;
        logic                  append_eoi;
        logic                  frame_end;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Bytes produced by the marker/body part of a command
    function automatic logic [LEN_WIDTH-1:0] head_len(input t_kind kind);
        logic [LEN_WIDTH-1:0] len;
        unique case (kind)
            K_NONE:  len = LEN_WIDTH'(0);
            K_PAD:   len = LEN_WIDTH'(1);
            K_EOI:   len = LEN_WIDTH'(1);
            K_BODY:  len = LEN_WIDTH'(1);
            K_SOI:   len = LEN_WIDTH'(2);
            default: len = LEN_WIDTH'(0);
        endcase
        return len;
    endfunction

    function automatic logic [LEN_WIDTH-1:0] cmd_len(input t_cmd cmd);
        return head_len(cmd.kind) + (cmd.append_eoi ? LEN_WIDTH'(2) : LEN_WIDTH'(0));
    endfunction

    function automatic logic [BYTE_WIDTH-1:0] cmd_byte(input t_cmd cmd,
                                                       input logic [IDX_WIDTH-1:0] idx);
        logic [LEN_WIDTH-1:0]  hlen;
        logic [LEN_WIDTH-1:0]  pos;
        logic [BYTE_WIDTH-1:0] b;
        hlen = head_len(cmd.kind);
        pos  = {1'b0, idx};
        if (pos < hlen) begin
            unique case (cmd.kind)
                K_PAD:   b = PAD_BYTE;
                K_EOI:   b = MARK_EOI;
                K_BODY:  b = cmd.data;
                K_SOI:   b = (idx == IDX_WIDTH'(0)) ? MARK_PREFIX : MARK_SOI;
                default: b = PAD_BYTE;
            endcase
        end else begin
            // appended end marker
            b = (pos == hlen) ? MARK_PREFIX : MARK_EOI;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

### hdl/jfe_front.sv
// Front part: accepts captured bytes, tracks frame/marker state, emits commands.
// Depends on jfe_pkg.
`default_nettype none

module jfe_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire  [jfe_pkg::CFG_WIDTH-1:0]      i_cfg_wr_data,
    input  wire                                i_valid,
    input  wire  [jfe_pkg::BYTE_WIDTH-1:0]     i_byte,
    output logic                               o_ready,
    input  jfe_pkg::t_q_status                 i_q_status,
    output logic                               o_push,
    output jfe_pkg::t_cmd                      o_cmd
);
    import jfe_pkg::*;

    logic [COUNT_WIDTH-1:0] r_frame_length;
    logic [BYTE_WIDTH-1:0]  r_prev;
    logic                   r_inside;
    logic                   r_footer;
    logic [COUNT_WIDTH-1:0] r_count;

    logic [COUNT_WIDTH-1:0] n_count;
    logic                   n_inside;
    logic                   n_footer;
    logic                   last;
    logic                   accept;
    t_kind                  kind;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign n_count = r_count + COUNT_WIDTH'(1);
    assign last    = (n_count == r_frame_length);

    // Classify: padding after end marker, then end-marker test, body, start marker
    always_comb begin
        kind     = K_NONE;
        n_inside = r_inside;
        n_footer = r_footer;
        priority if (r_footer) begin
            kind = K_PAD;
        end else if (i_byte == MARK_EOI && r_prev == MARK_PREFIX) begin
            kind     = K_EOI;
            n_inside = 1'b0;
            n_footer = 1'b1;
        end else if (r_inside) begin
            kind = K_BODY;
        end else if (i_byte == MARK_SOI && r_prev == MARK_PREFIX) begin
            kind     = K_SOI;
            n_inside = 1'b1;
        end else begin
            kind = K_NONE;
        end
    end

    always_comb begin
        o_cmd.kind       = kind;
        o_cmd.data       = i_byte;
        o_cmd.append_eoi = last && n_inside;
        o_cmd.frame_end  = last;
    end

    // drop bytes that produce no output
    assign o_push = accept && ((kind != K_NONE) || (last && n_inside));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= '0;
            r_prev         <= '0;
            r_inside       <= 1'b0;
            r_footer       <= 1'b0;
            r_count        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_length <= COUNT_WIDTH'(i_cfg_wr_data);
            end
            if (accept) begin
                if (last) begin
                    r_prev   <= '0;
                    r_inside <= 1'b0;
                    r_footer <= 1'b0;
                    r_count  <= '0;
                end else begin
                    r_prev   <= i_byte;
                    r_inside <= n_inside;
                    r_footer <= n_footer;
                    r_count  <= n_count;
                end
            end
        end
    end

endmodule

`default_nettype wire

### hdl/jfe_queue.sv
// Short command queue between front and back, register based.
// Depends on jfe_pkg.
`default_nettype none

module jfe_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  jfe_pkg::t_cmd        i_cmd,
    input  wire                  i_pop,
    output jfe_pkg::t_cmd        o_head,
    output jfe_pkg::t_q_status   o_status
);
    import jfe_pkg::*;

    t_cmd             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_CW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_status.empty = (r_count == Q_CW'(0));
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/jfe_back.sv
// Back part: expands queued commands into output bytes behind an output register.
// Depends on jfe_pkg.
`default_nettype none

module jfe_back (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  jfe_pkg::t_cmd                     i_head,
    input  jfe_pkg::t_q_status                i_q_status,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [jfe_pkg::BYTE_WIDTH-1:0]    o_byte,
    output logic                              o_last,
    output logic                              o_frame_end
);
    import jfe_pkg::*;

    logic [IDX_WIDTH-1:0]  r_idx;
    logic                  r_valid;
    logic [BYTE_WIDTH-1:0] r_byte;
    logic                  r_last;
    logic                  r_frame_end;

    logic                  advance;
    logic                  cmd_done;
    logic [LEN_WIDTH-1:0]  len;

    assign advance  = !r_valid || i_ready;
    assign len      = cmd_len(i_head);
    assign cmd_done = ({1'b0, r_idx} == len - LEN_WIDTH'(1));
    assign o_pop    = advance && !i_q_status.empty && cmd_done;

    assign o_valid     = r_valid;
    assign o_byte      = r_byte;
    assign o_last      = r_last;
    assign o_frame_end = r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (advance) begin
            if (!i_q_status.empty) begin
                r_valid <= 1'b1;
                r_idx   <= cmd_done ? '0 : r_idx + IDX_WIDTH'(1);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (advance && !i_q_status.empty) begin
            r_byte      <= cmd_byte(i_head, r_idx);
            r_last      <= cmd_done;
            r_frame_end <= i_head.frame_end;
        end
    end

endmodule

`default_nettype wire

### hdl/jpeg_frame_extractor_core.sv
// Top level of the JPEG frame extractor: front classifier, command queue, back expander.
// Depends on jfe_pkg, jfe_front, jfe_queue and jfe_back.
//
//  Channel   Dir  Signals                         Contents
//  --------  ---  ------------------------------  ----------------------------------------
//  s_axis    in   tvalid/tready/tdata[7:0]        captured byte (data_byte)
//  m_axis    out  tvalid/tready/tdata/tlast/tuser out_byte, run_last, frame_end
//  cfg       in   i_cfg_wr_en/i_cfg_wr_data[22:0] frame_length, written when wr_en is high
//
//  One input byte is taken per cycle while the four-entry command queue has room; each
//  byte yields zero to four output bytes, one per cycle, so the sustained rate is set by
//  the back expander: one output transfer per cycle while m_axis tready is high; input
//  stalls when the queue fills. Each byte passes the queue, then the output register.
//  Reset (i_rst_n low at a clock edge) clears frame state, frame_length, the queue and
//  the output register. Output stalls back up into the queue, then into s_axis tready.
`default_nettype none

module jpeg_frame_extractor_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration
    input  wire                               i_cfg_wr_en,
    input  wire  [jfe_pkg::CFG_WIDTH-1:0]     i_cfg_wr_data,
    // input stream
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [7:0]                        i_s_axis_tdata,   // [7:0] data_byte
    // output stream
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,   // [7:0] out_byte
    output logic                              o_m_axis_tlast,   // run_last
    output logic                              o_m_axis_tuser    // [0] frame_end
);
    import jfe_pkg::*;

    t_cmd      front_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Classify bytes and track SOI/EOI state
    jfe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .i_byte        (i_s_axis_tdata),
        .o_ready       (o_s_axis_tready),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // Decouple front from output backpressure
    jfe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    // Expand commands into output transfers
    jfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .o_frame_end (o_m_axis_tuser)
    );

`ifndef NO_ASSERTIONS
    // Front must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("command pushed into full queue");

    // Back must never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("command popped from empty queue");

    // Output register is empty right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A non-last output byte of a command is followed by more of the same command
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=> o_m_axis_tvalid)
        else $error("run broken before its last byte");
`endif

endmodule

`default_nettype wire

### tb/sv/jfe_stream_checker.sv
`timescale 1ns / 100ps
// Scoreboard for jpeg_frame_extractor_core: tracks frame state from s_axis transfers,
// predicts the m_axis bytes and compares each output transfer. Depends on jfe_pkg.
module jfe_stream_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire  [jfe_pkg::CFG_WIDTH-1:0] i_cfg_wr_data,
    input  wire                           i_s_tvalid,
    input  wire                           i_s_tready,
    input  wire  [7:0]                    i_s_tdata,   // [7:0] data_byte
    input  wire                           i_m_tvalid,
    input  wire                           i_m_tready,
    input  wire  [7:0]                    i_m_tdata,   // [7:0] out_byte
    input  wire                           i_m_tlast,   // run_last
    input  wire                           i_m_tuser,   // [0] frame_end
    output int                            o_errors,
    output int                            o_pending
);
    import jfe_pkg::*;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] out_byte;
        logic                  run_last;
        logic                  frame_end;
    } t_out_beat;

    t_out_beat              expected_beats[$];
    t_out_beat              beat;
    logic [CFG_WIDTH-1:0]   frame_len;
    logic [COUNT_WIDTH-1:0] bytes_taken;
    logic [BYTE_WIDTH-1:0]  prev_byte;
    logic                   in_image;
    logic                   eoi_seen;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Advance the frame state by one captured byte and queue the bytes it yields.
    function automatic void extract_byte(input logic [BYTE_WIDTH-1:0] cur);
        logic [BYTE_WIDTH-1:0]  emitted [0:3];
        int                     n;
        logic [COUNT_WIDTH-1:0] next_count;
        logic                   frame_done;
        t_out_beat              b;
        n          = 0;
        next_count = bytes_taken + 1'b1;
        frame_done = (next_count == COUNT_WIDTH'(frame_len));

        // end marker wins over everything but padding
        if (eoi_seen) begin
            emitted[n++] = PAD_BYTE;
        end else if (cur == MARK_EOI && prev_byte == MARK_PREFIX) begin
            emitted[n++] = MARK_EOI;
            eoi_seen     = 1'b1;
            in_image     = 1'b0;
        end else if (in_image) begin
            emitted[n++] = cur;
        end else if (cur == MARK_SOI && prev_byte == MARK_PREFIX) begin
            emitted[n++] = MARK_PREFIX;
            emitted[n++] = MARK_SOI;
            in_image     = 1'b1;
        end

        // close an image left open at frame end
        if (frame_done && in_image) begin
            emitted[n++] = MARK_PREFIX;
            emitted[n++] = MARK_EOI;
        end

        for (int k = 0; k < n; k++) begin
            b.out_byte  = emitted[k];
            b.run_last  = (k == n - 1);
            b.frame_end = frame_done;
            expected_beats.push_back(b);
        end

        if (frame_done) begin
            prev_byte   = '0;
            in_image    = 1'b0;
            eoi_seen    = 1'b0;
            bytes_taken = '0;
        end else begin
            prev_byte   = cur;
            bytes_taken = next_count;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_len   = '0;
            bytes_taken = '0;
            prev_byte   = '0;
            in_image    = 1'b0;
            eoi_seen    = 1'b0;
            expected_beats.delete();
        end else begin
            if (i_cfg_wr_en) begin
                frame_len = i_cfg_wr_data;
            end

            // check output first: no byte can come out in the cycle its input arrives
            if (i_m_tvalid && i_m_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected output transfer: out_byte %02h", i_m_tdata);
                    o_errors++;
                end else begin
                    beat = expected_beats.pop_front();
                    if (i_m_tdata !== beat.out_byte) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               beat.out_byte, i_m_tdata);
                        o_errors++;
                    end
                    if (i_m_tlast !== beat.run_last) begin
                        $error("run_last mismatch: expected %0b, actual %0b",
                               beat.run_last, i_m_tlast);
                        o_errors++;
                    end
                    if (i_m_tuser !== beat.frame_end) begin
                        $error("frame_end mismatch: expected %0b, actual %0b",
                               beat.frame_end, i_m_tuser);
                        o_errors++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                extract_byte(i_s_tdata);
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the testbench for jpeg_frame_extractor_core: clock, reset, stimulus and verdict.
// Depends on jfe_pkg, jfe_stream_checker and the RTL of the block.
module tb;
    import jfe_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 8;     // well past the queue and output register
    localparam int HOLD_CYCLES  = 150;   // long output hold-off
    localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
    localparam int PHASE_BYTES  = 12;
    localparam logic [CFG_WIDTH-1:0] CFG_MAX = '1;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_WIDTH-1:0] cfg_wr_data   = '0;
    logic                 s_tvalid      = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata       = '0;
    logic                 m_tvalid;
    logic                 m_tready      = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    int                   checker_errors;
    int                   checker_pending;

    // idling controls, written by the stimulus process only
    int                   tx_idle_pct   = 0;
    int                   rx_stall_pct  = 0;
    int                   hold_requests = 0;

    // receiver-side bookkeeping, written by the receiver process only
    int                   hold_served   = 0;
    int                   hold_left     = 0;

    int                   quiet_cycles  = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    jpeg_frame_extractor_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    jfe_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .i_m_tuser     (m_tuser),
        .o_errors      (checker_errors),
        .o_pending     (checker_pending)
    );

    // Receiver: on a hold request, drop tready until hold_left, loaded from HOLD_CYCLES, runs out;
    // otherwise stall at random by the current stall percentage.
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: end the run when no transfer happens on either stream for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Offer one byte and hold it until the transfer; the caller is at a falling edge.
    // Drop tvalid after the transfer; a next call raises it again at once unless it idles.
    task automatic push_byte(input logic [7:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    // Send count bytes packed left to right in seq (first byte in the highest lane used).
    task automatic push_seq(input logic [63:0] seq, input int count);
        for (int i = 0; i < count; i++) begin
            push_byte(seq[8*(count-1-i) +: 8]);
        end
    endtask

    // Wait for every predicted byte, then let the front finish any silent input.
    task automatic wait_drained();
        while (checker_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_frame_len(input logic [CFG_WIDTH-1:0] len);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = len;
        @(negedge i_clk);
        cfg_wr_en   = 1'b0;
    endtask

    // Random byte biased toward the marker bytes.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        case ($urandom_range(5))
            0:       b = MARK_PREFIX;
            1:       b = MARK_SOI;
            2:       b = MARK_EOI;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    // Build and send one frame of len bytes. Most frames carry a start marker after a
    // little junk, many of them an end marker too (then padding); the rest are
    // marker-heavy noise or an end marker with no image.
    task automatic send_frame(input int len, input bit force_image);
        logic [7:0] frame_bytes [0:63];
        int         style;
        int         soi_at;
        int         eoi_at;
        style = force_image ? 0 : $urandom_range(9);
        for (int i = 0; i < len; i++) begin
            frame_bytes[i] = (style >= 7) ? noise_byte() : 8'($urandom_range(255));
        end
        if (style <= 6 && len >= 2) begin
            soi_at = $urandom_range((len - 2) / 3);
            frame_bytes[soi_at]     = MARK_PREFIX;
            frame_bytes[soi_at + 1] = MARK_SOI;
            if (style <= 4 && soi_at + 4 <= len) begin
                eoi_at = $urandom_range(len - 2, soi_at + 2);
                frame_bytes[eoi_at]     = MARK_PREFIX;
                frame_bytes[eoi_at + 1] = MARK_EOI;
            end
        end else if (style == 9 && len >= 2) begin
            eoi_at = $urandom_range(len - 2);
            frame_bytes[eoi_at]     = MARK_PREFIX;
            frame_bytes[eoi_at + 1] = MARK_EOI;
        end
        for (int i = 0; i < len; i++) begin
            push_byte(frame_bytes[i]);
        end
    endtask

    initial begin
        int phase_bytes;
        int len_now;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames, no idling.
        // End marker with no image, then padding to the frame end.
        write_frame_len(CFG_WIDTH'(6));
        push_seq(64'hFFD900FF55AA, 6);
        // Start marker, a start marker inside the image passed as body,
        // frame ends inside the image so an end marker is appended.
        push_seq(64'h00FFD800FFD8, 6);
        // Start marker on the final byte: four bytes out of one input.
        write_frame_len(CFG_WIDTH'(4));
        push_seq(64'h1122FFD8, 4);
        // Frame with no image: nothing comes out, not even a frame end.
        write_frame_len(CFG_WIDTH'(3));
        push_seq(64'h00FF7F, 3);
        // One-byte frames: previous byte is cleared, so FF D8 is no marker here.
        write_frame_len(CFG_WIDTH'(1));
        push_seq(64'hFFD8, 2);

        // Random frames under four idling patterns.
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                if (mode == 0 && phase_bytes == 0) begin
                    // hold the output off while a long image streams in
                    write_frame_len(CFG_WIDTH'(16));
                    hold_requests++;
                    send_frame(16, 1'b1);
                    phase_bytes += 16;
                end else begin
                    len_now = $urandom_range(16, 2);
                    write_frame_len(CFG_WIDTH'(len_now));
                    send_frame(len_now, 1'b0);
                    phase_bytes += len_now;
                end
            end
        end

        // Extreme lengths: the frame never ends within the run. The second write lands
        // mid-frame, past the new length, so the frame runs on until the count wraps.
        write_frame_len(CFG_MAX);
        send_frame(14, 1'b1);
        write_frame_len('0);
        send_frame(12, 1'b0);

        wait_drained();
        if (checker_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hdl/jfe_pkg.sv
hdl/jfe_front.sv
hdl/jfe_queue.sv
hdl/jfe_back.sv
hdl/jpeg_frame_extractor_core.sv
tb/sv/jfe_stream_checker.sv
tb/sv/tb.sv
